// ----- hw/rtl/pvrm_pkg.sv -----
// Shared types and constants of the PCM voice resample mixer.
package pvrm_pkg;

    localparam int ACC_W      = 25;
    localparam int PCM_W      = 16;
    localparam int ADDR_IN_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int BUF_W      = 17;
    localparam int STEP_W     = 19;
    localparam int GAIN_W     = 16;
    localparam int CUR_W      = 18;
    localparam int FRAC_W     = 16;
    localparam int PART_W     = 17;
    localparam int NUM_W      = 34;
    localparam int PROD_W     = 52;
    localparam int CALC_W     = 25;

    // Item opcodes.
    localparam logic [2:0] OPC_WRITE  = 3'd0;
    localparam logic [2:0] OPC_PLAY   = 3'd1;
    localparam logic [2:0] OPC_STOP   = 3'd2;
    localparam logic [2:0] OPC_SETCUR = 3'd3;
    localparam logic [2:0] OPC_MIX    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_L  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_R  = 3'd5;

    localparam logic [BUF_W-1:0]  BUFFER_RESET = 17'h10000;
    localparam logic [STEP_W-1:0] STEP_RESET   = 19'h10000;
    localparam logic [GAIN_W-1:0] GAIN_UNITY   = 16'h8000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 25'sh0FFFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -25'sh1000000;
    localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;
    localparam logic [7:0] SILENCE_8 = 8'd128;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_CLEAR,
        DP_WRITE,
        DP_PLAY,
        DP_STOP,
        DP_MOD_ADDR,
        DP_SET_CURSOR,
        DP_MOD_FRAME,
        DP_WRAP_LOOP,
        DP_STOP_ONESHOT,
        DP_READ,
        DP_MUL1,
        DP_MUL2,
        DP_ADVANCE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] idx;
        logic       ch;
    } cmd_t;

    typedef struct packed {
        logic       clearing;
        logic       clear_last;
        logic       mod_busy;
        logic       mod_done;
        logic       playing;
        logic       looping;
        logic       cursor_ge_frames;
        logic       out_free;
        logic [2:0] opcode;
    } status_t;

endpackage

// ----- hw/rtl/pvrm_in_if.sv -----
// Input item channel of the voice.
interface pvrm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [2:0]                             opcode;
    logic [pvrm_pkg::ADDR_IN_W-1:0]         byte_address;
    logic [7:0]                             write_byte;
    logic                                   loop_flag;
    logic signed [pvrm_pkg::ACC_W-1:0]      acc_in_left;
    logic signed [pvrm_pkg::ACC_W-1:0]      acc_in_right;

    modport source (output valid, opcode, byte_address, write_byte, loop_flag,
                    acc_in_left, acc_in_right, input ready);
    modport sink (input valid, opcode, byte_address, write_byte, loop_flag,
                  acc_in_left, acc_in_right, output ready);
endinterface

// ----- hw/rtl/pvrm_out_if.sv -----
// Result item channel of the voice.
interface pvrm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pvrm_pkg::ACC_W-1:0]      acc_out_left;
    logic signed [pvrm_pkg::ACC_W-1:0]      acc_out_right;
    logic signed [pvrm_pkg::PCM_W-1:0]      pcm_left;
    logic signed [pvrm_pkg::PCM_W-1:0]      pcm_right;
    logic                                   is_playing;
    logic                                   is_looping;
    logic [pvrm_pkg::ADDR_IN_W-1:0]         cursor_bytes;

    modport source (output valid, acc_out_left, acc_out_right, pcm_left, pcm_right,
                    is_playing, is_looping, cursor_bytes, input ready);
    modport sink (input valid, acc_out_left, acc_out_right, pcm_left, pcm_right,
                  is_playing, is_looping, cursor_bytes, output ready);
endinterface

// ----- hw/rtl/pcm_voice_resample_mixer_top.sv -----
// Top level of the linear-interpolating PCM playback voice and mixer.
//
//   channel   | dir | handshake        | payload
//   cmd       | in  | valid / ready    | opcode, byte_address, write_byte, loop_flag, acc_in_*
//   result    | out | valid / ready    | acc_out_*, pcm_*, is_playing, is_looping, cursor_bytes
//   cfg       | in  | cfg_we           | cfg_index, cfg_data
//
// After reset the sample memory is cleared, one byte a cycle, over all RING_BYTES bytes;
// no item is taken until that pass is over, while configuration writes are taken.
// A write, play, stop or unused opcode goes from decode to the result step; set cursor
// also waits for the one-bit-a-cycle remainder unit. A mix item of a playing voice runs
// the eight byte reads through the one read port and two shared multiplies per channel,
// plus a remainder pass per end-of-ring wrap of a looping voice; a mix item of a
// stopped or past-the-end one-shot voice skips them. One item is in work at a time;
// a finished result waits in the output register, and the next item is taken meanwhile.
module pcm_voice_resample_mixer_top #(
    parameter int RING_BYTES = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pvrm_in_if.sink                              cmd,
    pvrm_out_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [pvrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pvrm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pvrm_pkg::cmd_t    dp_cmd;
    pvrm_pkg::status_t st;
    logic              in_ready;

    pvrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (dp_cmd)
    );

    pvrm_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .st            (st),
        .opcode        (cmd.opcode),
        .byte_address  (cmd.byte_address),
        .write_byte    (cmd.write_byte),
        .loop_flag     (cmd.loop_flag),
        .acc_in_left   (cmd.acc_in_left),
        .acc_in_right  (cmd.acc_in_right),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .acc_out_left  (result.acc_out_left),
        .acc_out_right (result.acc_out_right),
        .pcm_left      (result.pcm_left),
        .pcm_right     (result.pcm_right),
        .is_playing    (result.is_playing),
        .is_looping    (result.is_looping),
        .cursor_bytes  (result.cursor_bytes)
    );

    assign cmd.ready = in_ready;

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("item accepted while another is in work");

    // The remainder unit only runs inside an item.
    a_mod_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st.mod_busy |-> !cmd.ready)
        else $error("ready while remainder unit busy");

    // Nothing is taken or produced while the memory is being cleared.
    a_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        st.clearing |-> !cmd.ready && !result.valid)
        else $error("activity during memory clear");

    // A result command always shows up as a valid result item.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == pvrm_pkg::DP_RESULT |=> result.valid)
        else $error("result command without valid result");

endmodule

// ----- hw/rtl/pvrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pvrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/pvrm_mod.sv -----
// Iterative remainder unit: one restoring step per cycle.
module pvrm_mod #(
    parameter int W = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] rem,
    output logic         busy,
    output logic         done
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, num_reg[W-1]};
        if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_next = shifted[W-1:0];
            end
            num_next = {num_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/pvrm_datapath.sv -----
// Datapath: voice state, configuration, sample memory, interpolation and mixing.
module pvrm_datapath #(
    parameter int RING_BYTES = 65536
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pvrm_pkg::cmd_t                        cmd,
    output pvrm_pkg::status_t                     st,
    input  logic [2:0]                            opcode,
    input  logic [pvrm_pkg::ADDR_IN_W-1:0]        byte_address,
    input  logic [7:0]                            write_byte,
    input  logic                                  loop_flag,
    input  logic signed [pvrm_pkg::ACC_W-1:0]     acc_in_left,
    input  logic signed [pvrm_pkg::ACC_W-1:0]     acc_in_right,
    input  logic                                  cfg_we,
    input  logic [pvrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pvrm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [pvrm_pkg::ACC_W-1:0]     acc_out_left,
    output logic signed [pvrm_pkg::ACC_W-1:0]     acc_out_right,
    output logic signed [pvrm_pkg::PCM_W-1:0]     pcm_left,
    output logic signed [pvrm_pkg::PCM_W-1:0]     pcm_right,
    output logic                                  is_playing,
    output logic                                  is_looping,
    output logic [pvrm_pkg::ADDR_IN_W-1:0]        cursor_bytes
);

    localparam int ADDR_W  = $clog2(RING_BYTES);
    localparam int BUF_W   = pvrm_pkg::BUF_W;
    localparam int CUR_W   = pvrm_pkg::CUR_W;
    localparam int CALC_W  = pvrm_pkg::CALC_W;
    localparam int ACC_W   = pvrm_pkg::ACC_W;
    localparam int PCM_W   = pvrm_pkg::PCM_W;
    localparam int NUM_W   = pvrm_pkg::NUM_W;
    localparam int PROD_W  = pvrm_pkg::PROD_W;
    localparam int PART_W  = pvrm_pkg::PART_W;
    localparam logic [BUF_W-1:0] RING_LIM =
        BUF_W'((RING_BYTES > 131071) ? 131071 : RING_BYTES);
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(RING_BYTES - 1);

    // Configuration.
    logic                          stereo_reg;
    logic                          sixteen_reg;
    logic [BUF_W-1:0]              buffer_reg;
    logic [pvrm_pkg::STEP_W-1:0]   step_reg;
    logic [pvrm_pkg::GAIN_W-1:0]   gain_l_reg;
    logic [pvrm_pkg::GAIN_W-1:0]   gain_r_reg;

    // Latched item.
    logic [2:0]                    opcode_reg;
    logic [pvrm_pkg::ADDR_IN_W-1:0] addr_reg;
    logic [7:0]                    byte_reg;
    logic                          loop_reg;
    logic signed [ACC_W-1:0]       acc_l_reg;
    logic signed [ACC_W-1:0]       acc_r_reg;

    // Voice state.
    logic [CUR_W-1:0]              cursor_reg;
    logic [pvrm_pkg::FRAC_W-1:0]   frac_reg;
    logic                          playing_reg;
    logic                          looping_reg;

    logic                          clearing_reg;
    logic [ADDR_W-1:0]             clr_cnt_reg;

    logic [7:0]                    fb_reg [8];
    logic                          rd_pend_reg;
    logic [2:0]                    rd_idx_reg;

    logic signed [NUM_W-1:0]       num_reg;
    logic signed [PART_W-1:0]      part_l_reg;
    logic signed [PART_W-1:0]      part_r_reg;

    logic                          out_valid_reg;
    logic signed [ACC_W-1:0]       acc_out_l_reg;
    logic signed [ACC_W-1:0]       acc_out_r_reg;
    logic signed [PCM_W-1:0]       pcm_l_reg;
    logic signed [PCM_W-1:0]       pcm_r_reg;
    logic [pvrm_pkg::ADDR_IN_W-1:0] cursor_bytes_reg;
    logic                          play_out_reg;
    logic                          loop_out_reg;

    // Combinational signals.
    logic [1:0]                    fsh;
    logic [BUF_W-1:0]              b_clamp;
    logic [BUF_W-1:0]              frames;
    logic [BUF_W-1:0]              ring_span;
    logic [CUR_W-1:0]              f1_raw;
    logic [CUR_W-1:0]              f1;
    logic [CUR_W-1:0]              rd_frame;
    logic [CALC_W-1:0]             rd_full;
    logic [CALC_W-1:0]             wr_full;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [7:0]                    ram_wdata;
    logic [7:0]                    ram_rdata;
    logic                          use_right;
    logic signed [PCM_W-1:0]       s0;
    logic signed [PCM_W-1:0]       s1;
    logic signed [PCM_W:0]         diff;
    logic signed [NUM_W-1:0]       prod1;
    logic signed [NUM_W-1:0]       num_next;
    logic [pvrm_pkg::GAIN_W-1:0]   gain_sel;
    logic [pvrm_pkg::GAIN_W:0]     g;
    logic signed [PROD_W-1:0]      prod2;
    logic signed [PROD_W-1:0]      prod2_adj;
    logic signed [PART_W-1:0]      part_next;
    logic [19:0]                   total;
    logic                          mod_start;
    logic [CUR_W-1:0]              mod_dividend;
    logic [CUR_W-1:0]              mod_divisor;
    logic [CUR_W-1:0]              mod_rem;
    logic                          mod_busy;
    logic                          mod_done;
    logic signed [ACC_W:0]         sum_l;
    logic signed [ACC_W:0]         sum_r;
    logic signed [ACC_W-1:0]       sat_l;
    logic signed [ACC_W-1:0]       sat_r;
    logic [CUR_W+1:0]              cur_shift;

    function automatic logic signed [15:0] decode(input logic [31:0] bytes,
                                                  input logic wide,
                                                  input logic right);
        logic [7:0] b8;
        begin
            b8 = right ? bytes[15:8] : bytes[7:0];
            if (wide)
            begin
                decode = right ? bytes[31:16] : bytes[15:0];
            end
            else
            begin
                decode = {b8 ^ pvrm_pkg::SILENCE_8, 8'h00};
            end
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        begin
            if (v > (ACC_W+1)'(pvrm_pkg::ACC_MAX))
            begin
                sat_acc = pvrm_pkg::ACC_MAX;
            end
            else if (v < (ACC_W+1)'(pvrm_pkg::ACC_MIN))
            begin
                sat_acc = pvrm_pkg::ACC_MIN;
            end
            else
            begin
                sat_acc = v[ACC_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [PCM_W-1:0] clip16(input logic signed [ACC_W-1:0] v);
        begin
            if (v > ACC_W'(pvrm_pkg::PCM_MAX))
            begin
                clip16 = pvrm_pkg::PCM_MAX;
            end
            else if (v < ACC_W'(pvrm_pkg::PCM_MIN))
            begin
                clip16 = pvrm_pkg::PCM_MIN;
            end
            else
            begin
                clip16 = v[PCM_W-1:0];
            end
        end
    endfunction

    // Frame geometry: the frame size is a power of two, so it is a shift.
    always_comb
    begin
        fsh = {1'b0, stereo_reg} + {1'b0, sixteen_reg};
        if (buffer_reg < BUF_W'(4))
        begin
            b_clamp = BUF_W'(4);
        end
        else if (buffer_reg > RING_LIM)
        begin
            b_clamp = RING_LIM;
        end
        else
        begin
            b_clamp = buffer_reg;
        end
        frames    = b_clamp >> fsh;
        ring_span = frames << fsh;
    end

    // The next frame past the end goes to frame 0 when looping, else holds.
    always_comb
    begin
        f1_raw = cursor_reg + 1'b1;
        if (f1_raw >= CUR_W'(frames))
        begin
            f1 = looping_reg ? '0 : cursor_reg;
        end
        else
        begin
            f1 = f1_raw;
        end
        rd_frame = cmd.idx[2] ? f1 : cursor_reg;
        rd_full  = (CALC_W'(rd_frame) << fsh) + CALC_W'(cmd.idx[1:0]);
        wr_full  = CALC_W'(addr_reg);
    end

    always_comb
    begin
        if (cmd.op == pvrm_pkg::DP_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (cmd.op == pvrm_pkg::DP_WRITE) && (32'(addr_reg) < RING_BYTES);
            ram_waddr = wr_full[ADDR_W-1:0];
            ram_wdata = byte_reg;
        end
    end

    pvrm_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_full[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Interpolation arithmetic, one channel at a time.
    always_comb
    begin
        use_right = cmd.ch & stereo_reg;
        s0 = decode({fb_reg[3], fb_reg[2], fb_reg[1], fb_reg[0]}, sixteen_reg, use_right);
        s1 = decode({fb_reg[7], fb_reg[6], fb_reg[5], fb_reg[4]}, sixteen_reg, use_right);
        diff     = {s1[PCM_W-1], s1} - {s0[PCM_W-1], s0};
        prod1    = diff * $signed({1'b0, frac_reg});
        num_next = {{2{s0[PCM_W-1]}}, s0, 16'h0000} + prod1;
        gain_sel = cmd.ch ? gain_r_reg : gain_l_reg;
        g        = (gain_sel > pvrm_pkg::GAIN_UNITY) ? {1'b0, pvrm_pkg::GAIN_UNITY}
                                                     : {1'b0, gain_sel};
        prod2    = num_reg * $signed({1'b0, g});
        // Division by 2^31 truncates toward zero.
        prod2_adj = prod2 + (prod2[PROD_W-1] ? PROD_W'(32'h7FFF_FFFF) : PROD_W'(0));
        part_next = prod2_adj[47:31];
        total     = 20'(frac_reg) + 20'(step_reg);
        sum_l     = {acc_l_reg[ACC_W-1], acc_l_reg} + (ACC_W+1)'(part_l_reg);
        sum_r     = {acc_r_reg[ACC_W-1], acc_r_reg} + (ACC_W+1)'(part_r_reg);
        sat_l     = sat_acc(sum_l);
        sat_r     = sat_acc(sum_r);
        cur_shift = (CUR_W+2)'(cursor_reg) << fsh;
    end

    always_comb
    begin
        mod_start    = 1'b0;
        mod_dividend = cursor_reg;
        mod_divisor  = CUR_W'(frames);
        if (cmd.op == pvrm_pkg::DP_MOD_ADDR)
        begin
            mod_start    = 1'b1;
            mod_dividend = CUR_W'(addr_reg);
            mod_divisor  = CUR_W'(ring_span);
        end
        else if (cmd.op == pvrm_pkg::DP_MOD_FRAME)
        begin
            mod_start = 1'b1;
        end
    end

    pvrm_mod #(
        .W (CUR_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .rem      (mod_rem),
        .busy     (mod_busy),
        .done     (mod_done)
    );

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg    <= 1'b1;
            sixteen_reg   <= 1'b1;
            buffer_reg    <= pvrm_pkg::BUFFER_RESET;
            step_reg      <= pvrm_pkg::STEP_RESET;
            gain_l_reg    <= pvrm_pkg::GAIN_UNITY;
            gain_r_reg    <= pvrm_pkg::GAIN_UNITY;
            cursor_reg    <= '0;
            frac_reg      <= '0;
            playing_reg   <= 1'b0;
            looping_reg   <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pvrm_pkg::CFG_STEREO:  stereo_reg  <= cfg_data[0];
                    pvrm_pkg::CFG_SIXTEEN: sixteen_reg <= cfg_data[0];
                    pvrm_pkg::CFG_BUFFER:  buffer_reg  <= cfg_data[BUF_W-1:0];
                    pvrm_pkg::CFG_STEP:    step_reg    <= cfg_data;
                    pvrm_pkg::CFG_GAIN_L:  gain_l_reg  <= cfg_data[pvrm_pkg::GAIN_W-1:0];
                    pvrm_pkg::CFG_GAIN_R:  gain_r_reg  <= cfg_data[pvrm_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            rd_pend_reg <= (cmd.op == pvrm_pkg::DP_READ);

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                pvrm_pkg::DP_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLEAR_LAST)
                    begin
                        clearing_reg <= 1'b0;
                    end
                end
                pvrm_pkg::DP_PLAY:
                begin
                    playing_reg <= 1'b1;
                    looping_reg <= loop_reg;
                end
                pvrm_pkg::DP_STOP:
                begin
                    playing_reg <= 1'b0;
                end
                pvrm_pkg::DP_SET_CURSOR:
                begin
                    cursor_reg <= mod_rem >> fsh;
                    frac_reg   <= '0;
                end
                pvrm_pkg::DP_WRAP_LOOP:
                begin
                    cursor_reg <= mod_rem;
                end
                pvrm_pkg::DP_STOP_ONESHOT:
                begin
                    cursor_reg  <= '0;
                    frac_reg    <= '0;
                    playing_reg <= 1'b0;
                end
                pvrm_pkg::DP_ADVANCE:
                begin
                    cursor_reg <= cursor_reg + CUR_W'(total[19:16]);
                    frac_reg   <= total[15:0];
                end
                pvrm_pkg::DP_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            fb_reg[rd_idx_reg] <= ram_rdata;
        end
        if (cmd.op == pvrm_pkg::DP_READ)
        begin
            rd_idx_reg <= cmd.idx;
        end
        case (cmd.op)
            pvrm_pkg::DP_LOAD:
            begin
                opcode_reg <= opcode;
                addr_reg   <= byte_address;
                byte_reg   <= write_byte;
                loop_reg   <= loop_flag;
                acc_l_reg  <= acc_in_left;
                acc_r_reg  <= acc_in_right;
                part_l_reg <= '0;
                part_r_reg <= '0;
            end
            pvrm_pkg::DP_MUL1:
            begin
                num_reg <= num_next;
            end
            pvrm_pkg::DP_MUL2:
            begin
                if (cmd.ch)
                begin
                    part_r_reg <= part_next;
                end
                else
                begin
                    part_l_reg <= part_next;
                end
            end
            pvrm_pkg::DP_RESULT:
            begin
                if (opcode_reg == pvrm_pkg::OPC_MIX)
                begin
                    acc_out_l_reg <= sat_l;
                    acc_out_r_reg <= sat_r;
                    pcm_l_reg     <= clip16(sat_l);
                    pcm_r_reg     <= clip16(sat_r);
                end
                else
                begin
                    acc_out_l_reg <= '0;
                    acc_out_r_reg <= '0;
                    pcm_l_reg     <= '0;
                    pcm_r_reg     <= '0;
                end
                cursor_bytes_reg <= cur_shift[pvrm_pkg::ADDR_IN_W-1:0];
                // The voice state is held with the item, since the next item may
                // change it while this one waits.
                play_out_reg     <= playing_reg;
                loop_out_reg     <= looping_reg;
            end
            default: ;
        endcase
    end

    assign is_playing = play_out_reg;
    assign is_looping = loop_out_reg;

    always_comb
    begin
        st.clearing         = clearing_reg;
        st.clear_last       = (clr_cnt_reg == CLEAR_LAST);
        st.mod_busy         = mod_busy;
        st.mod_done         = mod_done;
        st.playing          = playing_reg;
        st.looping          = looping_reg;
        st.cursor_ge_frames = (cursor_reg >= CUR_W'(frames));
        st.out_free         = !out_valid_reg || out_ready;
        st.opcode           = opcode_reg;
    end

    assign out_valid     = out_valid_reg;
    assign acc_out_left  = acc_out_l_reg;
    assign acc_out_right = acc_out_r_reg;
    assign pcm_left      = pcm_l_reg;
    assign pcm_right     = pcm_r_reg;
    assign cursor_bytes  = cursor_bytes_reg;

endmodule

// ----- hw/rtl/pvrm_ctrl.sv -----
// Controller: sequences memory clearing, item decode, reads, multiplies and cursor update.
module pvrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pvrm_pkg::status_t st,
    output pvrm_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MOD_SET,
        S_WRAP_PRE,
        S_READ,
        S_READ_LAST,
        S_MUL1,
        S_MUL2,
        S_ADVANCE,
        S_ADV_CHECK,
        S_WRAP_POST,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        cmd.op     = pvrm_pkg::DP_NONE;
        cmd.idx    = cnt_reg;
        cmd.ch     = ch_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = pvrm_pkg::DP_CLEAR;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pvrm_pkg::DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (st.opcode)
                    pvrm_pkg::OPC_WRITE: cmd.op = pvrm_pkg::DP_WRITE;
                    pvrm_pkg::OPC_PLAY:  cmd.op = pvrm_pkg::DP_PLAY;
                    pvrm_pkg::OPC_STOP:  cmd.op = pvrm_pkg::DP_STOP;
                    pvrm_pkg::OPC_SETCUR:
                    begin
                        cmd.op     = pvrm_pkg::DP_MOD_ADDR;
                        state_next = S_MOD_SET;
                    end
                    pvrm_pkg::OPC_MIX:
                    begin
                        if (st.playing)
                        begin
                            if (!st.cursor_ge_frames)
                            begin
                                cnt_next   = '0;
                                state_next = S_READ;
                            end
                            else if (st.looping)
                            begin
                                cmd.op     = pvrm_pkg::DP_MOD_FRAME;
                                state_next = S_WRAP_PRE;
                            end
                            else
                            begin
                                cmd.op = pvrm_pkg::DP_STOP_ONESHOT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_MOD_SET:
            begin
                if (st.mod_done)
                begin
                    cmd.op     = pvrm_pkg::DP_SET_CURSOR;
                    state_next = S_DONE;
                end
            end
            S_WRAP_PRE:
            begin
                if (st.mod_done)
                begin
                    cmd.op     = pvrm_pkg::DP_WRAP_LOOP;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Bytes 0..3 of the current frame, then bytes 0..3 of the next one.
                cmd.op   = pvrm_pkg::DP_READ;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_READ_LAST;
                end
            end
            S_READ_LAST:
            begin
                ch_next    = 1'b0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = pvrm_pkg::DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op = pvrm_pkg::DP_MUL2;
                if (ch_reg)
                begin
                    state_next = S_ADVANCE;
                end
                else
                begin
                    ch_next    = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_ADVANCE:
            begin
                cmd.op     = pvrm_pkg::DP_ADVANCE;
                state_next = S_ADV_CHECK;
            end
            S_ADV_CHECK:
            begin
                state_next = S_DONE;
                if (st.cursor_ge_frames)
                begin
                    if (st.looping)
                    begin
                        cmd.op     = pvrm_pkg::DP_MOD_FRAME;
                        state_next = S_WRAP_POST;
                    end
                    else
                    begin
                        cmd.op = pvrm_pkg::DP_STOP_ONESHOT;
                    end
                end
            end
            S_WRAP_POST:
            begin
                if (st.mod_done)
                begin
                    cmd.op     = pvrm_pkg::DP_WRAP_LOOP;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.op     = pvrm_pkg::DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

// ----- sim/pvrm_voice_checker.sv -----
// Checker for the PCM voice: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps

module pvrm_voice_checker (
    input  logic clk,
    input  logic rst_n,
    pvrm_in_if   cmd,
    pvrm_out_if  result,
    input  logic                            cfg_we,
    input  logic [pvrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvrm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int   errors,
    output int   pending
);

    localparam int MEM_BYTES = 65536;
    localparam int ACC_W     = pvrm_pkg::ACC_W;
    localparam int PCM_W     = pvrm_pkg::PCM_W;
    localparam int ADDR_IN_W = pvrm_pkg::ADDR_IN_W;
    localparam int BUF_W     = pvrm_pkg::BUF_W;
    localparam int STEP_W    = pvrm_pkg::STEP_W;
    localparam int GAIN_W    = pvrm_pkg::GAIN_W;

    typedef struct {
        logic signed [ACC_W-1:0] acc_l;
        logic signed [ACC_W-1:0] acc_r;
        logic signed [PCM_W-1:0] pcm_l;
        logic signed [PCM_W-1:0] pcm_r;
        logic                    play;
        logic                    loop;
        logic [ADDR_IN_W-1:0]    cur;
    } mix_result_t;

    mix_result_t mix_queue[$];

    logic [7:0]        sample_mem [MEM_BYTES];
    int unsigned       cur_frame;
    int unsigned       cur_frac;
    bit                voice_on;
    bit                voice_loop;
    bit                cfg_stereo;
    bit                cfg_wide;
    logic [BUF_W-1:0]  cfg_buf;
    logic [STEP_W-1:0] cfg_step;
    logic [GAIN_W-1:0] cfg_gl;
    logic [GAIN_W-1:0] cfg_gr;

    function automatic int unsigned bytes_per_frame();
        return (int'(cfg_stereo) + 1) * (int'(cfg_wide) + 1);
    endfunction

    function automatic int unsigned frame_count();
        int unsigned b;
        b = 32'(cfg_buf);
        if (b < 4) b = 4;
        if (b > MEM_BYTES) b = MEM_BYTES;
        return b / bytes_per_frame();
    endfunction

    function automatic longint sample_at(int unsigned frame, int unsigned ch);
        int unsigned a;
        logic signed [15:0] w;
        a = frame * bytes_per_frame();
        if (cfg_wide)
        begin
            w = {sample_mem[a + ch * 2 + 1], sample_mem[a + ch * 2]};
            return longint'(w);
        end
        return (longint'(sample_mem[a + ch]) - 128) * 256;
    endfunction

    // End-of-ring rule; returns 0 when a one-shot voice stops.
    function automatic bit ring_wrap(int unsigned frames);
        if (cur_frame >= frames)
        begin
            if (voice_loop)
                cur_frame = cur_frame % frames;
            else
            begin
                cur_frame = 0;
                cur_frac  = 0;
                voice_on  = 0;
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic longint scaled_part(longint s0, longint s1, logic [GAIN_W-1:0] gain);
        longint g;
        longint num;
        g   = (gain > 16'd32768) ? 32768 : longint'(gain);
        num = s0 * 65536 + (s1 - s0) * longint'(cur_frac);
        return (num * g) / 64'sd2147483648;
    endfunction

    function automatic longint sat25(longint v);
        if (v > 16777215) return 16777215;
        if (v < -16777216) return -16777216;
        return v;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic predict_item();
        int unsigned frames;
        int unsigned fs;
        int unsigned f1;
        int unsigned total;
        longint al;
        longint ar;
        longint l0, l1, r0, r1;
        mix_result_t r;
        frames = frame_count();
        fs     = bytes_per_frame();
        al     = 0;
        ar     = 0;
        case (cmd.opcode)
            pvrm_pkg::OPC_WRITE:  sample_mem[cmd.byte_address] = cmd.write_byte;
            pvrm_pkg::OPC_PLAY:
            begin
                voice_on   = 1;
                voice_loop = cmd.loop_flag;
            end
            pvrm_pkg::OPC_STOP:   voice_on = 0;
            pvrm_pkg::OPC_SETCUR:
            begin
                cur_frame = (int'(cmd.byte_address) % (frames * fs)) / fs;
                cur_frac  = 0;
            end
            pvrm_pkg::OPC_MIX:
            begin
                al = longint'(cmd.acc_in_left);
                ar = longint'(cmd.acc_in_right);
                if (voice_on && ring_wrap(frames))
                begin
                    f1 = cur_frame + 1;
                    if (f1 >= frames) f1 = voice_loop ? 0 : cur_frame;
                    l0 = sample_at(cur_frame, 0);
                    l1 = sample_at(f1, 0);
                    r0 = cfg_stereo ? sample_at(cur_frame, 1) : l0;
                    r1 = cfg_stereo ? sample_at(f1, 1) : l1;
                    al += scaled_part(l0, l1, cfg_gl);
                    ar += scaled_part(r0, r1, cfg_gr);
                    total     = cur_frac + cfg_step;
                    cur_frame = cur_frame + (total >> 16);
                    cur_frac  = total & 32'hFFFF;
                    void'(ring_wrap(frames));
                end
                al = sat25(al);
                ar = sat25(ar);
            end
            default: ;
        endcase
        r.acc_l = al[ACC_W-1:0];
        r.acc_r = ar[ACC_W-1:0];
        r.pcm_l = PCM_W'(clip16(al));
        r.pcm_r = PCM_W'(clip16(ar));
        r.play  = voice_on;
        r.loop  = voice_loop;
        r.cur   = ADDR_IN_W'(cur_frame * fs);
        mix_queue = {mix_queue, r};
    endtask

    task automatic report(string field, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    task automatic compare_result();
        mix_result_t e;
        if (mix_queue.size() == 0)
        begin
            report("result count", 1, 0);
            return;
        end
        e = mix_queue.pop_front();
        if (result.acc_out_left !== e.acc_l) report("acc_out_left", result.acc_out_left, e.acc_l);
        if (result.acc_out_right !== e.acc_r)
            report("acc_out_right", result.acc_out_right, e.acc_r);
        if (result.pcm_left !== e.pcm_l) report("pcm_left", result.pcm_left, e.pcm_l);
        if (result.pcm_right !== e.pcm_r) report("pcm_right", result.pcm_right, e.pcm_r);
        if (result.is_playing !== e.play) report("is_playing", result.is_playing, e.play);
        if (result.is_looping !== e.loop) report("is_looping", result.is_looping, e.loop);
        if (result.cursor_bytes !== e.cur) report("cursor_bytes", result.cursor_bytes, e.cur);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (sample_mem[i]) sample_mem[i] = 8'd0;
            cur_frame  = 0;
            cur_frac   = 0;
            voice_on   = 0;
            voice_loop = 0;
            cfg_stereo = 1;
            cfg_wide   = 1;
            cfg_buf    = pvrm_pkg::BUFFER_RESET;
            cfg_step   = pvrm_pkg::STEP_RESET;
            cfg_gl     = pvrm_pkg::GAIN_UNITY;
            cfg_gr     = pvrm_pkg::GAIN_UNITY;
            errors     = 0;
            mix_queue.delete();
            pending    = 0;
        end
        else
        begin
            // Results leave before the new item is predicted; the block never
            // answers an item in the cycle it is taken.
            if (result.valid && result.ready) compare_result();
            if (cmd.valid && cmd.ready) predict_item();
            if (cfg_we)
            begin
                case (cfg_index)
                    pvrm_pkg::CFG_STEREO:  cfg_stereo = cfg_data[0];
                    pvrm_pkg::CFG_SIXTEEN: cfg_wide   = cfg_data[0];
                    pvrm_pkg::CFG_BUFFER:  cfg_buf    = cfg_data[BUF_W-1:0];
                    pvrm_pkg::CFG_STEP:    cfg_step   = cfg_data[STEP_W-1:0];
                    pvrm_pkg::CFG_GAIN_L:  cfg_gl     = cfg_data[GAIN_W-1:0];
                    pvrm_pkg::CFG_GAIN_R:  cfg_gr     = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            pending = mix_queue.size();
        end
    end

endmodule

// ----- sim/tb_pcm_voice_resample_mixer_top.sv -----
// Testbench top for the PCM voice: drives items and configuration, gives the verdict.
`timescale 1ns / 100ps

module tb_pcm_voice_resample_mixer_top;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int SETTLE       = 80;
    localparam int ACC_W        = pvrm_pkg::ACC_W;
    localparam int STEP_W       = pvrm_pkg::STEP_W;
    localparam int GAIN_W       = pvrm_pkg::GAIN_W;
    localparam int IDX_W        = pvrm_pkg::CFG_IDX_W;
    localparam int DATA_W       = pvrm_pkg::CFG_DATA_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   sent = 0;
    bit   calm = 0;
    int unsigned ring_bytes;

    pvrm_in_if  cmd_if ();
    pvrm_out_if res_if ();

    pcm_voice_resample_mixer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pvrm_voice_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = pvrm_pkg::OPC_WRITE;
        cmd_if.byte_address = '0;
        cmd_if.write_byte   = '0;
        cmd_if.loop_flag    = 1'b0;
        cmd_if.acc_in_left  = '0;
        cmd_if.acc_in_right = '0;
        res_if.ready        = 1'b0;
    end

    always @(negedge clk)
        res_if.ready <= calm || ($urandom_range(99) >= 13);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [2:0] op, logic [15:0] addr, logic [7:0] data,
                             logic loop, logic signed [ACC_W-1:0] al,
                             logic signed [ACC_W-1:0] ar);
        if (!calm && $urandom_range(99) < 13)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.byte_address <= addr;
        cmd_if.write_byte   <= data;
        cmd_if.loop_flag    <= loop;
        cmd_if.acc_in_left  <= al;
        cmd_if.acc_in_right <= ar;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Waits for every expected result and lets the block settle.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic signed [ACC_W-1:0] pick_acc();
        case ($urandom_range(5))
            0: return pvrm_pkg::ACC_MAX;
            1: return pvrm_pkg::ACC_MIN;
            2, 3: return $signed(25'($urandom_range(80000))) - 25'sd40000;
            default: return 25'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(7))
            0: return 19'd297;
            1: return 19'd297219;
            2: return 19'd0;
            3: return pvrm_pkg::STEP_RESET;
            4: return 19'($urandom);
            default: return 19'($urandom_range(300, 150000));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return pvrm_pkg::GAIN_UNITY;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic int unsigned pick_buffer();
        case ($urandom_range(9))
            0: return 0;
            1: return 3;
            2: return 4;
            3: return 65536;
            4: return 131071;
            5: return $urandom_range(131071);
            default: return $urandom_range(4, 64);
        endcase
    endfunction

    task automatic set_voice(bit st, bit wide, int unsigned buf_sz, logic [STEP_W-1:0] step,
                             logic [GAIN_W-1:0] gl, logic [GAIN_W-1:0] gr);
        cfg_write(pvrm_pkg::CFG_STEREO, DATA_W'(st));
        cfg_write(pvrm_pkg::CFG_SIXTEEN, DATA_W'(wide));
        cfg_write(pvrm_pkg::CFG_BUFFER, DATA_W'(buf_sz));
        cfg_write(pvrm_pkg::CFG_STEP, step);
        cfg_write(pvrm_pkg::CFG_GAIN_L, DATA_W'(gl));
        cfg_write(pvrm_pkg::CFG_GAIN_R, DATA_W'(gr));
        cfg_we <= 1'b0;
        ring_bytes = (buf_sz < 4) ? 4 : ((buf_sz > 65536) ? 65536 : buf_sz);
    endtask

    task automatic random_item();
        int unsigned k;
        logic [15:0] addr;
        k = $urandom_range(99);
        addr = (ring_bytes > 64) ? 16'($urandom) : 16'($urandom_range(ring_bytes - 1));
        if (k < 62)
            send_item(pvrm_pkg::OPC_MIX, 16'($urandom), 8'($urandom), 1'($urandom),
                      pick_acc(), pick_acc());
        else if (k < 74)
            send_item(pvrm_pkg::OPC_WRITE, ($urandom_range(9) == 0) ? 16'($urandom) : addr,
                      8'($urandom), 1'($urandom), pick_acc(), pick_acc());
        else if (k < 82)
            send_item(pvrm_pkg::OPC_SETCUR, ($urandom_range(3) == 0) ? 16'($urandom) : addr,
                      8'($urandom), 1'($urandom), pick_acc(), pick_acc());
        else if (k < 90)
            send_item(pvrm_pkg::OPC_PLAY, 16'($urandom), 8'($urandom), 1'($urandom),
                      pick_acc(), pick_acc());
        else if (k < 96)
            send_item(pvrm_pkg::OPC_STOP, 16'($urandom), 8'($urandom), 1'($urandom),
                      pick_acc(), pick_acc());
        else
            send_item(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 1'($urandom),
                      pick_acc(), pick_acc());
    endtask

    initial
    begin
        int phase;
        int target;
        bit wide;
        phase = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: small 8-bit stereo ring, then the extremes.
        set_voice(1'b1, 1'b0, 8, pvrm_pkg::STEP_RESET >> 1, pvrm_pkg::GAIN_UNITY, 16'hFFFF);
        send_item(pvrm_pkg::OPC_WRITE, 16'd0, 8'd255, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_WRITE, 16'd1, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_WRITE, 16'd2, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_WRITE, 16'd3, 8'd255, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_WRITE, 16'd65535, 8'hA5, 1'b1, pvrm_pkg::ACC_MAX,
                  pvrm_pkg::ACC_MIN);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, pvrm_pkg::ACC_MAX, pvrm_pkg::ACC_MIN);
        send_item(pvrm_pkg::OPC_PLAY, 16'd0, 8'd0, 1'b1, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, pvrm_pkg::ACC_MAX, pvrm_pkg::ACC_MIN);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, 25'sd30000, -25'sd30000);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_SETCUR, 16'hFFFF, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(3'd5, 16'hFFFF, 8'hFF, 1'b1, pvrm_pkg::ACC_MIN, pvrm_pkg::ACC_MAX);
        send_item(3'd6, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(3'd7, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_PLAY, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, -25'sd1, 25'sd1);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_STOP, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, 25'sd100, 25'sd100);
        drain();

        // A ring shrunk to two 16-bit mono frames, zero step: a looping voice mixes twice.
        set_voice(1'b0, 1'b1, 4, 19'd0, 16'd0, pvrm_pkg::GAIN_UNITY);
        send_item(pvrm_pkg::OPC_PLAY, 16'd0, 8'd0, 1'b1, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        send_item(pvrm_pkg::OPC_MIX, 16'd0, 8'd0, 1'b0, '0, '0);
        drain();

        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            calm = (phase >= 8 && phase < 12);
            wide = 1'($urandom);
            set_voice(1'($urandom), wide, pick_buffer(), pick_step(), pick_gain(),
                      pick_gain());
            // Load the start of the ring with random content, the silence byte now and then.
            for (int i = 0; i < ((ring_bytes > 32) ? 32 : ring_bytes); i++)
                send_item(pvrm_pkg::OPC_WRITE, 16'(i),
                          ($urandom_range(7) == 0) ? pvrm_pkg::SILENCE_8 : 8'($urandom),
                          1'($urandom), pick_acc(), pick_acc());
            send_item(pvrm_pkg::OPC_PLAY, 16'($urandom), 8'($urandom),
                      1'($urandom_range(3) != 0), pick_acc(), pick_acc());
            repeat ($urandom_range(20, 50)) random_item();
            drain();
            phase++;
        end
        calm = 0;

        // One more pass at reset values so the widest ring and unity gains close the run.
        set_voice(1'b1, 1'b1, 65536, pvrm_pkg::STEP_RESET, pvrm_pkg::GAIN_UNITY,
                  pvrm_pkg::GAIN_UNITY);
        send_item(pvrm_pkg::OPC_PLAY, 16'd0, 8'd0, 1'b1, '0, '0);
        repeat (10) random_item();
        drain();

        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pvrm_pkg.sv
hw/rtl/pvrm_in_if.sv
hw/rtl/pvrm_out_if.sv
hw/rtl/pvrm_ram.sv
hw/rtl/pvrm_mod.sv
hw/rtl/pvrm_datapath.sv
hw/rtl/pvrm_ctrl.sv
hw/rtl/pcm_voice_resample_mixer_top.sv
sim/pvrm_voice_checker.sv
sim/tb_pcm_voice_resample_mixer_top.sv
